### rtl/pid_pkg.sv
// Shared types and constants of the PID controller.
package pid_pkg;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GAIN_P = 2'd0;
	localparam cfg_idx_t REG_GAIN_I = 2'd1;
	localparam cfg_idx_t REG_GAIN_D = 2'd2;
	localparam cfg_idx_t REG_TARGET = 2'd3;

	// Multiplier bits consumed by the shared unit in one cycle.
	localparam int MUL_DIGIT = 8;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_INTEG,
		ST_DIV,
		ST_DERIV,
		ST_MUL_P,
		ST_ADD_P,
		ST_MUL_K,
		ST_ADD_K,
		ST_MUL_D,
		ST_FINISH
	} pid_state_t;

endpackage

### rtl/pid_controller.sv
// Positional PID controller in signed fixed point with one shared multiply and divide unit.
// Per request: integral multiply, radix-2 restoring divide for the derivative (skipped when
// the time step is zero or the derivative quotient needs more than DATA_WIDTH bits), then
// the P, I and D multiplies; all four multiplies use 8-bit digits on one adder shared with
// the divide. No new request is taken until the last result is in the output register.
// Reset (arst_n low, asynchronous): gains, setpoint, integral and stored error clear to zero,
// the sequencer returns to idle and no result is pending.
module pid_controller #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  pid_pkg::cfg_idx_t                  cfg_index,
	input  logic [DATA_WIDTH-1:0]              cfg_data,
	// Input stream. s_tdata from bit 0 up: measured, time_step, zero padding.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((2*DATA_WIDTH+6)/8)*8-1:0]  s_tdata,
	// Result stream. m_tdata from bit 0 up: drive, zero padding.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
	// m_tuser from bit 0 up: zero_step.
	output logic                               m_tuser
);
	import pid_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int CH    = MUL_DIGIT;
	localparam int NCH   = (W + CH - 1) / CH;          // multiply steps per product
	localparam int RW    = NCH * CH;                   // multiplier register width
	localparam int MW    = W + RW;                     // multiplicand register width
	localparam int AW    = MW + 1;                     // accumulator width
	localparam int SW    = AW + 2;                     // width for sums before saturation
	localparam int NUMW  = W + 1 + F;                  // scaled error difference
	localparam int CMPW  = (F + 1 > W) ? F + 1 : W;    // width of the divide overflow compare
	localparam int CNTW  = $clog2(W);
	localparam int OUT_W = ((W + 7) / 8) * 8;

	localparam logic signed [W-1:0] D_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] D_MIN = {1'b1, {(W-1){1'b0}}};

	// Clamp a wide signed value to the data range.
	function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
		logic [SW-W:0] top;
		top = v[SW-1:W-1];
		if (top == '0 || top == '1)
			return v[W-1:0];
		return v[SW-1] ? D_MIN : D_MAX;
	endfunction

	// Configuration and controller state.
	logic signed [W-1:0] gain_p_q, gain_i_q, gain_d_q, target_q;
	logic signed [W-1:0] integral_q, last_err_q;

	pid_state_t state_q, state_n;
	logic [CNTW-1:0] cnt_q;
	logic out_valid_q;

	// Datapath registers.
	logic signed [AW-1:0] acc_q;
	logic signed [MW-1:0] mcand_q;
	logic [RW-1:0]        mplier_q;
	logic signed [W-1:0]  err_q, deriv_q;
	logic signed [SW-1:0] drv_q;
	logic [W-2:0]         dt_q;
	logic                 zero_q, neg_q;
	logic signed [W-1:0]  drive_q;
	logic                 zero_out_q;

	// Input fields.
	logic signed [W-1:0] meas_in;
	logic [W-2:0]        dt_in;
	assign meas_in = $signed(s_tdata[W-1:0]);
	assign dt_in   = s_tdata[2*W-2:W];

	logic s_accept, out_free, last_mul, last_div;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign last_mul = (cnt_q == CNTW'(NCH - 1));
	assign last_div = (cnt_q == CNTW'(W - 1));

	// The error of a new sample, saturated.
	logic signed [SW-1:0] err_wide;
	logic signed [W-1:0]  err_new;
	assign err_wide = SW'(target_q) - SW'(meas_in);
	assign err_new  = sat_w(err_wide);

	// ---------------------------------------------------------------------
	// Shared unit: one adder that either accumulates an 8-bit-digit partial
	// product (multiply) or trial-subtracts the time step (restoring divide).
	// ---------------------------------------------------------------------
	logic                 div_mode;
	logic                 dsgn;
	logic signed [CH:0]   digit;
	logic signed [AW-1:0] mcand_ext;
	logic signed [AW+CH:0] pp_full;
	logic [W-1:0]         trial;
	logic [AW-1:0]        unit_a, unit_b, unit_sum;
	logic                 geq;
	logic [W-1:0]         rem_n;

	// Only the top digit of the multiplier carries the sign.
	assign dsgn      = last_mul && mplier_q[CH-1];
	assign digit     = $signed({dsgn, mplier_q[CH-1:0]});
	assign mcand_ext = AW'(mcand_q);
	assign pp_full   = mcand_ext * digit;

	assign trial    = {acc_q[2*W-2:W], acc_q[W-1]};
	assign unit_a   = div_mode ? AW'(trial) : acc_q;
	assign unit_b   = div_mode ? ~AW'(dt_q) : pp_full[AW-1:0];
	assign unit_sum = unit_a + unit_b + AW'(div_mode);
	assign geq      = !unit_sum[AW-1];
	assign rem_n    = geq ? unit_sum[W-1:0] : trial;

	// Finished product scaled back to the fixed-point grid (floor).
	logic signed [AW-1:0] prod_sh;
	assign prod_sh = acc_q >>> F;

	logic signed [SW-1:0] integ_wide, drive_wide;
	assign integ_wide = SW'(integral_q) + SW'(prod_sh);
	assign drive_wide = drv_q + SW'(prod_sh);

	// Divide setup: |err - last_err| * 2^F over dt, quotient limited to W bits.
	logic signed [W:0]   diff;
	logic [W:0]          mag;
	logic [NUMW-1:0]     num;
	logic [CMPW-1:0]     num_hi, dt_cmp;
	logic                ovf;
	assign diff   = (W+1)'(err_q) - (W+1)'(last_err_q);
	assign mag    = diff[W] ? (W+1)'(-diff) : diff;
	assign num    = {mag, {F{1'b0}}};
	assign num_hi = CMPW'(num[NUMW-1:W]);
	assign dt_cmp = CMPW'(dt_q);
	assign ovf    = (num_hi >= dt_cmp);

	// Signed quotient, saturated.
	logic signed [SW-1:0] quo_wide;
	assign quo_wide = neg_q ? -SW'($signed({1'b0, acc_q[W-1:0]}))
	                        :  SW'($signed({1'b0, acc_q[W-1:0]}));

	// ---------------------------------------------------------------------
	// Sequencer: next state.
	// ---------------------------------------------------------------------
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_accept) state_n = ST_MUL_I;
			ST_MUL_I:  if (last_mul) state_n = ST_INTEG;
			ST_INTEG:  state_n = (zero_q || ovf) ? ST_MUL_P : ST_DIV;
			ST_DIV:    if (last_div) state_n = ST_DERIV;
			ST_DERIV:  state_n = ST_MUL_P;
			ST_MUL_P:  if (last_mul) state_n = ST_ADD_P;
			ST_ADD_P:  state_n = ST_MUL_K;
			ST_MUL_K:  if (last_mul) state_n = ST_ADD_K;
			ST_ADD_K:  state_n = ST_MUL_D;
			ST_MUL_D:  if (last_mul) state_n = ST_FINISH;
			ST_FINISH: if (out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// Sequencer: outputs and operand selection for the next multiply.
	logic                mul_load;
	logic signed [W-1:0] load_a, load_b;

	always_comb begin
		s_tready  = 1'b0;
		div_mode  = 1'b0;
		mul_load  = 1'b0;
		load_a    = err_new;
		load_b    = $signed({1'b0, dt_in});
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				mul_load = s_accept;
			end
			ST_INTEG: begin
				mul_load = zero_q || ovf;
				load_a   = gain_p_q;
				load_b   = err_q;
			end
			ST_DIV: begin
				div_mode = 1'b1;
			end
			ST_DERIV: begin
				mul_load = 1'b1;
				load_a   = gain_p_q;
				load_b   = err_q;
			end
			ST_ADD_P: begin
				mul_load = 1'b1;
				load_a   = gain_i_q;
				load_b   = integral_q;
			end
			ST_ADD_K: begin
				mul_load = 1'b1;
				load_a   = gain_d_q;
				load_b   = deriv_q;
			end
			ST_MUL_I, ST_MUL_P, ST_MUL_K, ST_MUL_D, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------------
	// Control state, configuration and persistent controller state.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			target_q    <= '0;
			integral_q  <= '0;
			last_err_q  <= '0;
		end else begin
			state_q <= state_n;
			// The step counter restarts on every state change.
			cnt_q   <= (state_n != state_q) ? '0 : cnt_q + 1'b1;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GAIN_P: gain_p_q <= $signed(cfg_data);
					REG_GAIN_I: gain_i_q <= $signed(cfg_data);
					REG_GAIN_D: gain_d_q <= $signed(cfg_data);
					REG_TARGET: target_q <= $signed(cfg_data);
				endcase
			end

			if (state_q == ST_INTEG)
				integral_q <= sat_w(integ_wide);

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				last_err_q  <= err_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Datapath.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mul_load) begin
			mcand_q  <= MW'(load_a);
			mplier_q <= RW'(load_b);
			acc_q    <= '0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					err_q  <= err_new;
					dt_q   <= dt_in;
					zero_q <= (dt_in == '0);
				end
			end
			ST_MUL_I, ST_MUL_P, ST_MUL_K, ST_MUL_D: begin
				acc_q    <= $signed(unit_sum);
				mcand_q  <= mcand_q <<< CH;
				mplier_q <= mplier_q >> CH;
			end
			ST_INTEG: begin
				neg_q <= diff[W];
				if (zero_q)
					deriv_q <= '0;
				else if (ovf)
					deriv_q <= diff[W] ? D_MIN : D_MAX;
				else
					acc_q <= $signed(AW'({num_hi[W-1:0], num[W-1:0]}));
			end
			ST_DIV: begin
				// Remainder in the upper half, quotient bits shift in below.
				acc_q <= $signed(AW'({rem_n, acc_q[W-2:0], geq}));
			end
			ST_DERIV: begin
				deriv_q <= sat_w(quo_wide);
			end
			ST_ADD_P: begin
				drv_q <= SW'(prod_sh);
			end
			ST_ADD_K: begin
				drv_q <= drive_wide;
			end
			ST_FINISH: begin
				if (out_free) begin
					drive_q    <= sat_w(drive_wide);
					zero_out_q <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'($unsigned(drive_q));
	assign m_tuser  = zero_out_q;

endmodule

### rtl/pid_checker.sv
// Port-level checks of the PID controller and their binding to it.
module pid_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
	input logic                               m_tuser
);

	// A pending result stays until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The controller is busy right after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while the previous one is in work");

	// No result can be finished in the cycle after a request is taken.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// An idle controller stays ready until a request arrives.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("idle controller lost ready");

endmodule

bind pid_controller pid_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_pid_checker (.*);

### sim/tb.sv
// Self-checking testbench for the positional PID controller: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
	import pid_pkg::*;

	localparam int DW   = 32;
	localparam int FRAC = 16;
	localparam int S_W  = ((2*DW+6)/8)*8;
	localparam int M_W  = ((DW+7)/8)*8;

	// Saturation bounds of the 32-bit signed data path, and 1.0 in Q16.16.
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam longint ONE_Q  = 64'sd65536;

	// Idle cycles before a register write, once every result has come back.
	localparam int SETTLE = 8;
	// Cycles allowed to pass after the last result before the verdict.
	localparam int DRAIN = 60;
	// Random part: phases of one register setting each.
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 322;
	// Long receiver hold-offs, so the block fills up and stalls its input.
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_SPACING = 700;
	// The worst legal quiet stretch is a hold-off plus one request plus the longest sender
	// gap, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 40;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// One row of the directed table. For a register write, word is the data; for a
	// request, word is the measured value. Rows marked typed carry their own result.
	typedef struct {
		row_kind_t   kind;
		cfg_idx_t    idx;
		logic [31:0] word;
		logic [30:0] dt;
		bit          typed;
		logic [31:0] drive;
		logic        zero_step;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] drive;
		logic        zero_step;
	} pid_result_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	cfg_idx_t       cfg_index = REG_GAIN_P;
	logic [DW-1:0]  cfg_data  = '0;
	logic           s_tvalid  = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata   = '0;
	logic           m_tvalid;
	logic           m_tready  = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           m_tuser;

	// Local copy of the controller: register shadows and the two state words.
	logic [31:0] kp_r = '0;
	logic [31:0] ki_r = '0;
	logic [31:0] kd_r = '0;
	logic [31:0] sp_r = '0;
	longint      integ_acc = 0;
	longint      prev_err  = 0;

	// Results still owed by the block, oldest first.
	pid_result_t drive_q[$];
	stim_row_t   dir_tab[$];

	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned stall_cycles = 0;
	int unsigned rx_cyc       = 0;
	int          hold_left    = 0;
	int unsigned next_hold_at = 150;

	cfg_idx_t reg_order[4] = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_TARGET};

	pid_controller #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FRAC)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// Advances the local controller by one request and returns the result it owes.
	// Products are exact and floored by the arithmetic shift; the derivative quotient
	// truncates toward zero, which is what signed division does.
	task automatic pid_update(input logic [31:0] meas, input logic [30:0] dt,
			output pid_result_t res);
		longint m;
		longint t;
		longint err;
		longint deriv;
		longint drv;
		m = longint'($signed(meas));
		t = {33'd0, dt};
		err = clamp32(longint'($signed(sp_r)) - m);
		integ_acc = clamp32(integ_acc + ((err * t) >>> FRAC));
		// A zero time step has no derivative; the integral gains nothing on its own.
		if (t == 0)
			deriv = 0;
		else
			deriv = clamp32(((err - prev_err) * ONE_Q) / t);
		drv = ((longint'($signed(kp_r)) * err) >>> FRAC)
			+ ((longint'($signed(ki_r)) * integ_acc) >>> FRAC)
			+ ((longint'($signed(kd_r)) * deriv) >>> FRAC);
		drv = clamp32(drv);
		prev_err = err;
		res.drive = drv[31:0];
		res.zero_step = (t == 0);
	endtask

	function automatic void add_cfg(input cfg_idx_t idx, input logic [31:0] val);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, word: val, dt: '0, typed: 1'b0, drive: '0,
			zero_step: 1'b0};
		dir_tab.push_back(r);
	endfunction

	function automatic void add_item(input logic [31:0] meas, input logic [30:0] dt,
			input bit typed, input logic [31:0] drive, input logic zs);
		stim_row_t r;
		r = '{kind: ROW_ITEM, idx: REG_GAIN_P, word: meas, dt: dt, typed: typed,
			drive: drive, zero_step: zs};
		dir_tab.push_back(r);
	endfunction

	// Offers one request from the current falling edge until it is taken, then books
	// the expected result. It returns on the next falling edge with tvalid still high,
	// so a burst can go on without lowering it.
	task automatic send_sample(input logic [31:0] meas, input logic [30:0] dt,
			input bit typed, input pid_result_t typed_res);
		pid_result_t res;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, dt, meas};
		do @(posedge clk); while (!s_tready);
		pid_update(meas, dt, res);
		if (typed)
			res = typed_res;
		drive_q.push_back(res);
		@(negedge clk);
	endtask

	// Writes one register once the block has gone idle. The caller has already lowered
	// s_tvalid. Returns on a falling edge with cfg_valid lowered.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		do @(negedge clk); while (drive_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_P: kp_r = val;
			REG_GAIN_I: ki_r = val;
			REG_GAIN_D: kd_r = val;
			REG_TARGET: sp_r = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: every accepted result is matched against the oldest expectation,
	// field by field. An unexpected result is a failure as well.
	always @(posedge clk) begin
		pid_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual drive %h zero_step %b",
						$time, m_tdata, m_tuser);
			end else begin
				want = drive_q.pop_front();
				if (m_tdata != want.drive) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: drive mismatch, expected %h, actual %h",
							$time, want.drive, m_tdata);
				end
				if (m_tuser != want.zero_step) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: zero_step mismatch, expected %b, actual %b",
							$time, want.zero_step, m_tuser);
				end
			end
		end
	end

	// Receiver back-pressure. Every so many results it holds off for a long stretch,
	// counted here, while the sender keeps offering requests. Otherwise it cycles
	// through always ready, coin-flip, mostly stalled and a fixed 3-of-5 pattern.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (results_seen >= next_hold_at) begin
			hold_left = HOLD_CYCLES;
			next_hold_at += HOLD_SPACING;
			m_tready <= 1'b0;
		end else begin
			rx_cyc++;
			case (rx_cyc[7:6])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((rx_cyc % 5) < 3);
			endcase
		end
	end

	// Watchdog: a long run of cycles with no accepted request on any channel means
	// the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int unsigned burst_left;
		logic [31:0] meas;
		logic [31:0] val;
		logic [30:0] dt;
		pid_result_t typed_res;

		// Directed table. With all gains zero after reset the drive is zero whatever
		// comes in, so those rows are typed; so are all later rows up to the mixed gains, the
		// saturation rows each pinned to a rail. The mixed-gain rows at the end go to the predictor.
		add_item(32'h0000_0000, 31'h0000_0000, 1, 32'h0000_0000, 1'b1);
		// Most positive measured value with the longest time step drives the integral
		// to its negative rail.
		add_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 32'h0000_0000, 1'b0);
		// Most negative measured value: the error leaves the range and saturates.
		add_item(32'h8000_0000, 31'h0000_0001, 1, 32'h0000_0000, 1'b0);
		add_cfg(REG_GAIN_P, 32'h0001_0000);
		// Unit gain: an error of 1.0 gives a drive of 1.0.
		add_item(32'hFFFF_0000, 31'h0001_0000, 1, 32'h0001_0000, 1'b0);
		// Zero time step with a proportional term only.
		add_item(32'h0001_2345, 31'h0000_0000, 1, 32'hFFFE_DCBB, 1'b1);
		add_cfg(REG_GAIN_P, 32'h7FFF_FFFF);
		add_cfg(REG_TARGET, 32'h7FFF_FFFF);
		// Largest gain on the largest error: the output saturates high, then low.
		add_item(32'h8000_0000, 31'h0000_0001, 1, 32'h7FFF_FFFF, 1'b0);
		add_cfg(REG_GAIN_P, 32'h8000_0000);
		add_item(32'h8000_0000, 31'h0000_0001, 1, 32'h8000_0000, 1'b0);
		add_cfg(REG_GAIN_P, 32'h0000_0000);
		add_cfg(REG_GAIN_I, 32'h0001_0000);
		add_cfg(REG_TARGET, 32'h0000_0000);
		// Integral pushed to its positive rail, then to its negative rail.
		add_item(32'h8000_0000, 31'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0);
		add_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 32'h8000_0000, 1'b0);
		add_cfg(REG_GAIN_I, 32'h0000_0000);
		add_cfg(REG_GAIN_D, 32'h0001_0000);
		// Full-scale error swing over the shortest step: the derivative saturates.
		add_item(32'h0000_0000, 31'h0000_0001, 1, 32'h7FFF_FFFF, 1'b0);
		add_item(32'h0000_0000, 31'h0000_0000, 1, 32'h0000_0000, 1'b1);
		add_item(32'h7FFF_FFFF, 31'h0000_0001, 1, 32'h8000_0000, 1'b0);
		// Unchanged error: no derivative at all.
		add_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 32'h0000_0000, 1'b0);
		// Mixed gains, one of them negative; rounding of products and quotient matters.
		add_cfg(REG_GAIN_P, 32'h0001_8000);
		add_cfg(REG_GAIN_I, 32'hFFFF_8000);
		add_cfg(REG_GAIN_D, 32'h0000_4000);
		add_cfg(REG_TARGET, 32'h0005_0000);
		add_item(32'h0001_0000, 31'h0000_8000, 0, '0, 1'b0);
		add_item(32'hFFFF_0001, 31'h0000_0003, 0, '0, 1'b0);
		add_item(32'h0005_0000, 31'h0001_0000, 0, '0, 1'b0);
		add_item(32'h0012_3456, 31'h0000_0001, 0, '0, 1'b0);
		add_item(32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, '0, 1'b0);
		add_item(32'h0000_0000, 31'h0000_0000, 0, '0, 1'b0);
		add_item(32'h8000_0000, 31'h0000_0002, 0, '0, 1'b0);
		add_item(32'h7FFF_FFFF, 31'h0000_0001, 0, '0, 1'b0);
		add_item(32'h0004_8000, 31'h0000_1000, 0, '0, 1'b0);

		// Reset is released on a falling edge, away from the rising edge.
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].kind == ROW_CFG) begin
				write_reg(dir_tab[k].idx, dir_tab[k].word);
			end else begin
				typed_res.drive = dir_tab[k].drive;
				typed_res.zero_step = dir_tab[k].zero_step;
				send_sample(dir_tab[k].word, dir_tab[k].dt, dir_tab[k].typed, typed_res);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
		end

		// Random phases. The first two put every register on one rail; the rest mix
		// rails, zero, small values between -4.0 and 4.0 in Q16.16 and full-range values.
		burst_left = $urandom_range(1, 12);
		for (int phase = 0; phase < PHASES; phase++) begin
			foreach (reg_order[r]) begin
				if (phase == 0)
					val = 32'h7FFF_FFFF;
				else if (phase == 1)
					val = 32'h8000_0000;
				else begin
					case ($urandom_range(0, 5))
						0: val = 32'h7FFF_FFFF;
						1: val = 32'h8000_0000;
						2: val = 32'h0000_0000;
						5: val = $urandom;
						default: val = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
					endcase
				end
				write_reg(reg_order[r], val);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Half of the samples sit near the setpoint, so the loop stays off
				// the rails long enough for the rounding to show.
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: meas = sp_r + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
					5: begin
						case ($urandom_range(0, 3))
							0: meas = 32'h7FFF_FFFF;
							1: meas = 32'h8000_0000;
							2: meas = 32'h0000_0000;
							default: meas = 32'hFFFF_FFFF;
						endcase
					end
					6, 7: meas = $urandom;
					default: meas = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
				endcase
				case ($urandom_range(0, 9))
					0: dt = '0;
					1: dt = 31'd1;
					2: dt = 31'h7FFF_FFFF;
					3, 4, 5, 6: dt = 31'($urandom_range(0, 32'h2_0000));
					default: dt = 31'($urandom);
				endcase
				send_sample(meas, dt, 0, '0);

				burst_left--;
				if (burst_left == 0 || n == PHASE_ITEMS - 1) begin
					s_tvalid <= 1'b0;
					burst_left = $urandom_range(1, 12);
					if ($urandom_range(0, 15) == 0) begin
						// Let the block run dry before the next request.
						do @(negedge clk); while (drive_q.size() != 0);
					end else if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(20, 80) + 1) @(negedge clk);
					end else begin
						repeat ($urandom_range(0, 5) + 1) @(negedge clk);
					end
				end
			end
		end

		// Wait for the last results, then give the block time to show anything extra.
		while (drive_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
